// File: hdl/prt_pkg.sv
package prt_pkg;

  localparam int TABLE_DEPTH    = 32;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W         = 32;
  localparam int PORT_W         = 16;
  localparam int TIME_W         = 32;
  localparam int BYTE_W         = 8;
  localparam int WIN_W          = 8;
  localparam int LEN_W          = 9;
  localparam int BYTES_PER_PEER = 5;

  localparam logic [BYTE_W-1:0] REPLY_MARK   = 8'd8;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 8'd10;

  // one table slot as held in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // scan events handed to the result stage
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic              finish;
  } scan_ev_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

// File: hdl/prt_ram.sv
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/prt_emit.sv
module prt_emit import prt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ev_t          ev,
  output logic              out_strobe,
  output logic              out_has_reply,
  output logic [ADDR_W-1:0] out_peer_address_out,
  output logic [LEN_W-1:0]  out_reply_length,
  output logic              out_last
);

  localparam int PROD_W = CNT_W + 3;

  // one peer held back so the final one can carry last and the length
  logic              pend_vld_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              strobe_r;
  logic              has_reply_r;
  logic [ADDR_W-1:0] peer_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;
  logic [PROD_W-1:0] len_full;

  assign len_full = PROD_W'(cnt_r) * PROD_W'(BYTES_PER_PEER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (ev.hit) begin
        strobe_r   <= pend_vld_r;
        pend_vld_r <= 1'b1;
        cnt_r      <= cnt_r + 1'b1;
      end else if (ev.finish) begin
        strobe_r   <= 1'b1;
        pend_vld_r <= 1'b0;
        cnt_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev.hit) begin
      pend_addr_r <= ev.addr;
      has_reply_r <= 1'b1;
      peer_r      <= pend_addr_r;
      len_r       <= '0;
      last_r      <= 1'b0;
    end else if (ev.finish) begin
      has_reply_r <= pend_vld_r;
      peer_r      <= pend_vld_r ? pend_addr_r : '0;
      len_r       <= pend_vld_r ? LEN_W'(len_full) : '0;
      last_r      <= 1'b1;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_has_reply        = has_reply_r;
  assign out_peer_address_out = peer_r;
  assign out_reply_length     = len_r;
  assign out_last             = last_r;

endmodule

// File: hdl/peer_rendezvous_table_core.sv
// Peer rendezvous table. A datagram (sender address, port, time, first byte)
// is taken on start while busy is low. A first byte of 8 is a reply: it is
// dropped in the accept cycle and busy stays low. Any other datagram scans
// all TABLE_DEPTH slots, one per cycle through the single read port of the
// slot RAM, then writes the sender back to its own slot, else to the first
// spare one if any; busy is high through the scan and the write-back. Each
// fresh same-port peer gives one result transaction; results are strobed
// on out_strobe for exactly one cycle and the receiver cannot stall them.
// A peer is held back until the next peer is found and leaves in the cycle
// after that peer's slot is read; the final transaction (out_last set,
// reply_length = 5 bytes per peer) appears in the first cycle after busy
// falls. A datagram that reports nobody gives a single transaction with
// has_reply low. The user must write the window register via cfg_wr_en /
// cfg_wr_data only while idle (not enforced); its reset value is 10 s.
// Slot valid bits sit in flops cleared by reset, so no clearing pass is run.
module peer_rendezvous_table_core import prt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] in_sender_address,
  input  logic [PORT_W-1:0] in_sender_port,
  input  logic [TIME_W-1:0] in_now_seconds,
  input  logic [BYTE_W-1:0] in_first_byte,
  input  logic              cfg_wr_en,
  input  logic [WIN_W-1:0]  cfg_wr_data,
  output logic              out_strobe,
  output logic              out_has_reply,
  output logic [ADDR_W-1:0] out_peer_address_out,
  output logic [LEN_W-1:0]  out_reply_length,
  output logic              out_last
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  state_t                 state_r, state_nxt;
  logic [WIN_W-1:0]       window_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]       idx_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [PORT_W-1:0]      port_r;
  logic [TIME_W-1:0]      now_r;
  logic                   own_hit_r;
  logic [IDX_W-1:0]       own_idx_r;
  logic                   spare_hit_r;
  logic [IDX_W-1:0]       spare_idx_r;

  logic                   accept;
  logic                   scanning;
  logic                   flushing;
  logic [IDX_W-1:0]       rd_addr;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic                   ram_we;
  logic [IDX_W-1:0]       wr_addr;
  logic                   same_port;
  logic                   same_addr;
  logic [TIME_W-1:0]      age;
  logic                   fresh;
  logic                   is_own;
  logic                   is_peer;
  logic                   is_spare;
  scan_ev_t               ev;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign scanning = (state_r == ST_SCAN);
  assign flushing = (state_r == ST_FLUSH);

  // slot 0 is fetched in the accept cycle; the scan then runs one slot ahead
  always_comb begin
    rd_addr = '0;
    if (scanning && (idx_r != IDX_LAST)) begin
      rd_addr = idx_r + 1'b1;
    end
  end

  // classify the slot whose data has just come out of the RAM
  assign same_port = valid_r[idx_r] && (rd_entry.port == port_r);
  assign same_addr = (rd_entry.address == addr_r);
  assign age       = now_r - rd_entry.stamp;   // wraps mod 2^32
  assign fresh     = (age <= TIME_W'(window_r));
  assign is_own    = scanning && same_port && same_addr;
  assign is_peer   = scanning && same_port && !same_addr && fresh;
  assign is_spare  = scanning && !is_own && !is_peer;

  // sender goes back to its own slot, else to the first spare one
  assign ram_we   = flushing && (own_hit_r || spare_hit_r);
  assign wr_addr  = own_hit_r ? own_idx_r : spare_idx_r;
  assign wr_entry = '{address: addr_r, port: port_r, stamp: now_r};

  prt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_first_byte != REPLY_MARK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      valid_r     <= '0;
      own_hit_r   <= 1'b0;
      spare_hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (accept) begin
        own_hit_r   <= 1'b0;
        spare_hit_r <= 1'b0;
      end
      if (is_own) begin
        own_hit_r <= 1'b1;
      end
      if (is_spare) begin
        spare_hit_r <= 1'b1;
      end
      if (ram_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // payload and slot indices, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_sender_address;
      port_r <= in_sender_port;
      now_r  <= in_now_seconds;
      idx_r  <= '0;
    end else if (scanning && (idx_r != IDX_LAST)) begin
      idx_r <= idx_r + 1'b1;
    end
    if (is_own) begin
      own_idx_r <= idx_r;            // last own slot wins
    end
    if (is_spare && !spare_hit_r) begin
      spare_idx_r <= idx_r;          // first spare slot wins
    end
  end

  assign ev = '{hit: is_peer, addr: rd_entry.address, finish: flushing};

  prt_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ev                   (ev),
    .out_strobe           (out_strobe),
    .out_has_reply        (out_has_reply),
    .out_peer_address_out (out_peer_address_out),
    .out_reply_length     (out_reply_length),
    .out_last             (out_last)
  );

  // a reply datagram never starts a scan
  a_reply_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_first_byte == REPLY_MARK)) |=> !busy)
    else $error("reply datagram started a scan");

  // the closing transaction follows the write-back cycle
  a_last_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flushing |=> (out_strobe && out_last))
    else $error("no closing transaction after write-back");

  // only the closing transaction may lack a peer
  a_mid_has_peer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (out_has_reply && (out_reply_length == '0)))
    else $error("bad intermediate transaction");

  // no transaction is produced while idle unless it closes a datagram
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !$past(flushing)) |-> $past(scanning))
    else $error("transaction outside a scan");

endmodule
